// ----- rtl/gap_pkg.sv -----
// ----------------------------------------------------------------------------
// gap_pkg: shared types and constants of the grid A* path finder
// Step costs, the unreached mark and the Euclidean distance table.
// ----------------------------------------------------------------------------
package gap_pkg;

  localparam int unsigned CostW = 17;
  localparam logic [CostW-1:0] Unreached = 17'h1FFFF;
  localparam logic [CostW-1:0] CostStraight = 17'd1000;
  localparam logic [CostW-1:0] CostDiag = 17'd1414;

  localparam logic KindWrite = 1'b0;
  localparam logic KindFind = 1'b1;

  typedef logic [13:0] dist_t;

  function automatic dist_t dist_milli(input logic [2:0] dx, input logic [2:0] dy);
    logic [5:0] idx;
    dist_t      r;
    idx = {dx, dy};
    unique case (idx)
      6'd0: r = 14'd0;     6'd1: r = 14'd1000;  6'd2: r = 14'd2000;  6'd3: r = 14'd3000;
      6'd4: r = 14'd4000;  6'd5: r = 14'd5000;  6'd6: r = 14'd6000;  6'd7: r = 14'd7000;
      6'd8: r = 14'd1000;  6'd9: r = 14'd1414;  6'd10: r = 14'd2236; 6'd11: r = 14'd3162;
      6'd12: r = 14'd4123; 6'd13: r = 14'd5099; 6'd14: r = 14'd6083; 6'd15: r = 14'd7071;
      6'd16: r = 14'd2000; 6'd17: r = 14'd2236; 6'd18: r = 14'd2828; 6'd19: r = 14'd3606;
      6'd20: r = 14'd4472; 6'd21: r = 14'd5385; 6'd22: r = 14'd6325; 6'd23: r = 14'd7280;
      6'd24: r = 14'd3000; 6'd25: r = 14'd3162; 6'd26: r = 14'd3606; 6'd27: r = 14'd4243;
      6'd28: r = 14'd5000; 6'd29: r = 14'd5831; 6'd30: r = 14'd6708; 6'd31: r = 14'd7616;
      6'd32: r = 14'd4000; 6'd33: r = 14'd4123; 6'd34: r = 14'd4472; 6'd35: r = 14'd5000;
      6'd36: r = 14'd5657; 6'd37: r = 14'd6403; 6'd38: r = 14'd7211; 6'd39: r = 14'd8062;
      6'd40: r = 14'd5000; 6'd41: r = 14'd5099; 6'd42: r = 14'd5385; 6'd43: r = 14'd5831;
      6'd44: r = 14'd6403; 6'd45: r = 14'd7071; 6'd46: r = 14'd7810; 6'd47: r = 14'd8602;
      6'd48: r = 14'd6000; 6'd49: r = 14'd6083; 6'd50: r = 14'd6325; 6'd51: r = 14'd6708;
      6'd52: r = 14'd7211; 6'd53: r = 14'd7810; 6'd54: r = 14'd8485; 6'd55: r = 14'd9220;
      6'd56: r = 14'd7000; 6'd57: r = 14'd7071; 6'd58: r = 14'd7280; 6'd59: r = 14'd7616;
      6'd60: r = 14'd8062; 6'd61: r = 14'd8602; 6'd62: r = 14'd9220; 6'd63: r = 14'd9899;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/gap_ram.sv -----
// ----------------------------------------------------------------------------
// gap_ram: generic simple dual-port RAM
// One write and one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module gap_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/grid_astar_path_finder.sv -----
// ----------------------------------------------------------------------------
// grid_astar_path_finder: 8-connected A* search over a small square grid
// Keeps the obstacle map and searches paths from start to goal.
// ----------------------------------------------------------------------------
// A write item updates the obstacle RAM. A find item runs a sequencer over three
// RAMs: a node RAM holding {open, g, parent} per cell, the obstacle RAM and a
// path RAM. Setup sweeps all cells (one per cycle), each pop scans all cells
// and then closes the cell and expands each neighbor inside the grid. The path
// walk stores the cells from goal back to start in the path RAM, and each result
// item is read back from it in start-to-goal order. A start equal to the goal
// gives its result in the cycle after the item is taken. Results wait in an
// output register; the next item is taken once the last result has left.
// After reset the obstacle RAM is cleared before any item.
module grid_astar_path_finder
  import gap_pkg::*;
#(
  parameter int unsigned GRID_SIDE = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [2:0] cell_x_i,
  input  logic [2:0] cell_y_i,
  input  logic       blocked_i,
  input  logic [2:0] goal_x_i,
  input  logic [2:0] goal_y_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       found_o,
  output logic [2:0] step_x_o,
  output logic [2:0] step_y_o,
  output logic       last_o
);

  localparam int unsigned Cells = GRID_SIDE * GRID_SIDE;
  localparam int unsigned AW = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned CW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int unsigned NodeW = 1 + CostW + AW;
  localparam logic [AW:0] CellsL = AW'(Cells-1) + (AW+1)'(1);
  localparam logic [CW-1:0] SideMax = CW'(GRID_SIDE - 1);
  localparam logic signed [CW+1:0] Step1 = (CW+2)'(1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_POP   = 4'd4;
  localparam logic [3:0] S_NRD   = 4'd5;
  localparam logic [3:0] S_NUPD  = 4'd6;
  localparam logic [3:0] S_GOAL  = 4'd7;
  localparam logic [3:0] S_WALK  = 4'd8;
  localparam logic [3:0] S_WSTO  = 4'd9;
  localparam logic [3:0] S_ERD   = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_q, state_d, ret_q, ret_d;
  logic [AW:0] cnt_q, cnt_d;
  logic [CW-1:0] gx_q, gx_d, gy_q, gy_d;
  logic [AW-1:0] s_q, s_d, g_q, g_d, cur_q, cur_d, at_q, at_d;
  logic [CostW-1:0] curg_q, curg_d;
  logic have_q, have_d;
  logic [CostW:0] bestf_q, bestf_d;
  logic [AW-1:0] besti_q, besti_d;
  logic [3:0] dir_q, dir_d;
  logic [AW-1:0] nb_q, nb_d;
  logic diag_q, diag_d;
  logic [AW:0] n_q, n_d;
  logic ov_q, ov_d, of_q, of_d, ol_q, ol_d;
  logic [2:0] ox_q, ox_d, oy_q, oy_d;

  logic nd_we, ob_we, ps_we;
  logic [AW-1:0] nd_wa, nd_ra, ob_wa, ob_ra, ps_wa, ps_ra;
  logic [NodeW-1:0] nd_wd, nd_rd;
  logic ob_wd, ob_rd;
  logic [AW-1:0] ps_wd, ps_rd;

  gap_ram #(.Width(NodeW), .Depth(Cells)) u_node (
    .clk_i, .we_i(nd_we), .waddr_i(nd_wa), .wdata_i(nd_wd), .raddr_i(nd_ra), .rdata_o(nd_rd));
  gap_ram #(.Width(1), .Depth(Cells)) u_obst (
    .clk_i, .we_i(ob_we), .waddr_i(ob_wa), .wdata_i(ob_wd), .raddr_i(ob_ra), .rdata_o(ob_rd));
  gap_ram #(.Width(AW), .Depth(Cells)) u_path (
    .clk_i, .we_i(ps_we), .waddr_i(ps_wa), .wdata_i(ps_wd), .raddr_i(ps_ra), .rdata_o(ps_rd));

  logic nd_open;
  logic [CostW-1:0] nd_g;
  logic [AW-1:0] nd_par;
  assign nd_open = nd_rd[NodeW-1];
  assign nd_g = nd_rd[AW +: CostW];
  assign nd_par = nd_rd[AW-1:0];

  function automatic logic [CW-1:0] cx(input logic [AW-1:0] i);
    return CW'(i % GRID_SIDE);
  endfunction
  function automatic logic [CW-1:0] cy(input logic [AW-1:0] i);
    return CW'(i / GRID_SIDE);
  endfunction
  function automatic logic [AW-1:0] idx(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return AW'(y * GRID_SIDE + x);
  endfunction

  // f value (g plus heuristic) for the cell addressed in the previous cycle (cnt_q - 1)
  logic [AW-1:0] scan_i;
  logic [CW-1:0] sxx, syy, hdx, hdy;
  logic [CostW:0] fval;
  always_comb begin
    scan_i = AW'(cnt_q - (AW+1)'(1));
    sxx = cx(scan_i);
    syy = cy(scan_i);
    hdx = (sxx > gx_q) ? sxx - gx_q : gx_q - sxx;
    hdy = (syy > gy_q) ? syy - gy_q : gy_q - syy;
    fval = (CostW+1)'(nd_g) + (CostW+1)'(dist_milli(3'(hdx), 3'(hdy)));
  end

  // neighbor of cur in direction dir
  logic signed [CW+1:0] nx, ny;
  logic nvalid;
  always_comb begin
    nx = $signed({2'b00, cx(cur_q)});
    ny = $signed({2'b00, cy(cur_q)});
    unique case (dir_q[2:0])
      3'd0: ny = ny - Step1;
      3'd1: begin nx = nx + Step1; ny = ny - Step1; end
      3'd2: nx = nx + Step1;
      3'd3: begin nx = nx + Step1; ny = ny + Step1; end
      3'd4: ny = ny + Step1;
      3'd5: begin nx = nx - Step1; ny = ny + Step1; end
      3'd6: nx = nx - Step1;
      default: begin nx = nx - Step1; ny = ny - Step1; end
    endcase
    nvalid = (nx >= 0) && (ny >= 0) && (nx <= $signed({2'b00, SideMax}))
             && (ny <= $signed({2'b00, SideMax}));
  end

  logic [CostW:0] tent;
  assign tent = (CostW+1)'(curg_q) + (CostW+1)'(diag_q ? CostDiag : CostStraight);

  logic in_ok;
  assign in_stall_o = (state_q != S_IDLE) || ov_q;
  assign in_ok = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q; ret_d = ret_q; cnt_d = cnt_q;
    gx_d = gx_q; gy_d = gy_q; s_d = s_q; g_d = g_q; cur_d = cur_q; at_d = at_q;
    curg_d = curg_q; have_d = have_q; bestf_d = bestf_q; besti_d = besti_q;
    dir_d = dir_q; nb_d = nb_q; diag_d = diag_q; n_d = n_q;
    ov_d = ov_q; of_d = of_q; ol_d = ol_q; ox_d = ox_q; oy_d = oy_q;
    nd_we = 1'b0; nd_wa = '0; nd_wd = '0; nd_ra = '0;
    ob_we = 1'b0; ob_wa = '0; ob_wd = 1'b0; ob_ra = '0;
    ps_we = 1'b0; ps_wa = '0; ps_wd = '0; ps_ra = '0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      S_CLR: begin
        ob_we = 1'b1; ob_wa = AW'(cnt_q);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CellsL - 1'b1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_ok) begin
          if (kind_i == KindWrite) begin
            if (cell_x_i <= 3'(SideMax) && cell_y_i <= 3'(SideMax)) begin
              ob_we = 1'b1; ob_wa = idx(CW'(cell_x_i), CW'(cell_y_i)); ob_wd = blocked_i;
            end
          end else if (cell_x_i > 3'(SideMax) || cell_y_i > 3'(SideMax)
                       || goal_x_i > 3'(SideMax) || goal_y_i > 3'(SideMax)) begin
            ov_d = 1'b1; of_d = 1'b0; ol_d = 1'b1; ox_d = '0; oy_d = '0;
          end else if (cell_x_i == goal_x_i && cell_y_i == goal_y_i) begin
            ov_d = 1'b1; of_d = 1'b1; ol_d = 1'b1; ox_d = cell_x_i; oy_d = cell_y_i;
          end else begin
            gx_d = CW'(goal_x_i); gy_d = CW'(goal_y_i);
            s_d = idx(CW'(cell_x_i), CW'(cell_y_i));
            g_d = idx(CW'(goal_x_i), CW'(goal_y_i));
            cnt_d = '0;
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        nd_we = 1'b1; nd_wa = AW'(cnt_q);
        nd_wd = (AW'(cnt_q) == s_q) ? {1'b1, {CostW{1'b0}}, {AW{1'b0}}}
                                    : {1'b0, Unreached, {AW{1'b0}}};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CellsL - 1'b1) begin
          cnt_d = '0; have_d = 1'b0; state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // address cnt, evaluate data of cnt-1
        nd_ra = AW'(cnt_q);
        if (cnt_q != '0 && nd_open && (!have_q || fval < bestf_q)) begin
          have_d = 1'b1; bestf_d = fval; besti_d = scan_i;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CellsL) state_d = S_POP;
      end
      S_POP: begin
        if (!have_q) begin
          state_d = S_GOAL;
        end else begin
          cur_d = besti_q;
          nd_ra = besti_q;
          state_d = (besti_q == g_q) ? S_GOAL : S_NRD;
          ret_d = S_POP;
          dir_d = 4'd15;
        end
      end
      S_NRD: begin
        if (dir_q == 4'd15) begin
          // node of cur readable now: close it
          curg_d = nd_g;
          nd_we = 1'b1; nd_wa = cur_q; nd_wd = {1'b0, nd_g, nd_par};
          dir_d = 4'd0;
        end else if (dir_q[3]) begin
          cnt_d = '0; have_d = 1'b0; state_d = S_SCAN;
        end else if (!nvalid) begin
          dir_d = dir_q + 1'b1;
        end else begin
          nb_d = idx(CW'(nx), CW'(ny));
          diag_d = dir_q[0];
          nd_ra = idx(CW'(nx), CW'(ny));
          ob_ra = idx(CW'(nx), CW'(ny));
          state_d = S_NUPD;
        end
        if (dir_q == 4'd15) begin
          // goal check was already done in POP; after closing, move on
          state_d = S_NRD;
        end
      end
      S_NUPD: begin
        if (!ob_rd && tent < (CostW+1)'(Unreached) && tent < (CostW+1)'(nd_g)) begin
          nd_we = 1'b1; nd_wa = nb_q; nd_wd = {1'b1, CostW'(tent), cur_q};
        end
        dir_d = dir_q + 1'b1;
        state_d = S_NRD;
      end
      S_GOAL: begin
        // goal popped or no open cell left: read goal to test reachability
        nd_ra = g_q;
        state_d = S_WALK;
        n_d = '0; at_d = g_q;
      end
      S_WALK: begin
        // nd_rd holds node of at
        if (n_q == '0 && nd_g == Unreached) begin
          ov_d = 1'b1; of_d = 1'b0; ol_d = 1'b1; ox_d = '0; oy_d = '0;
          state_d = S_OUT; ret_d = S_IDLE;
        end else if (at_q == s_q) begin
          ps_we = 1'b1; ps_wa = AW'(n_q); ps_wd = s_q;
          n_d = n_q + 1'b1;
          state_d = S_ERD;
        end else if (n_q >= (AW+1)'(Cells - 1)) begin
          ov_d = 1'b1; of_d = 1'b0; ol_d = 1'b1; ox_d = '0; oy_d = '0;
          state_d = S_OUT; ret_d = S_IDLE;
        end else begin
          ps_we = 1'b1; ps_wa = AW'(n_q); ps_wd = at_q;
          n_d = n_q + 1'b1;
          at_d = nd_par;
          state_d = S_WSTO;
        end
      end
      S_WSTO: begin
        nd_ra = at_q;
        state_d = S_WALK;
      end
      S_ERD: begin
        if (!ov_q || !out_stall_i) begin
          ps_ra = AW'(n_q - 1'b1);
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        ov_d = 1'b1; of_d = 1'b1;
        ox_d = 3'(cx(ps_rd)); oy_d = 3'(cy(ps_rd));
        ol_d = (n_q == (AW+1)'(1));
        n_d = n_q - 1'b1;
        if (n_q == (AW+1)'(1)) begin
          state_d = S_OUT; ret_d = S_IDLE;
        end else begin
          state_d = S_ERD;
        end
      end
      S_OUT: begin
        if (!ov_q || !out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; ret_q <= S_IDLE; cnt_q <= '0; ov_q <= 1'b0; have_q <= 1'b0;
    end else begin
      state_q <= state_d; ret_q <= ret_d; cnt_q <= cnt_d; ov_q <= ov_d; have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gx_q <= gx_d; gy_q <= gy_d; s_q <= s_d; g_q <= g_d; cur_q <= cur_d; at_q <= at_d;
    curg_q <= curg_d; bestf_q <= bestf_d; besti_q <= besti_d; dir_q <= dir_d;
    nb_q <= nb_d; diag_q <= diag_d; n_q <= n_d;
    of_q <= of_d; ol_q <= ol_d; ox_q <= ox_d; oy_q <= oy_d;
  end

  assign out_valid_o = ov_q;
  assign found_o = of_q;
  assign step_x_o = ox_q;
  assign step_y_o = oy_q;
  assign last_o = ol_q;

endmodule

// ----- rtl/gap_checker.sv -----
// ----------------------------------------------------------------------------
// gap_checker: port-level checks of the grid A* path finder
// Watches the handshakes and the result framing.
// ----------------------------------------------------------------------------
module gap_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       found_o,
  input logic [2:0] step_x_o,
  input logic [2:0] step_y_o,
  input logic       last_o
);

  logic busy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && last_o) begin
      busy_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      busy_q <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(step_x_o) && $stable(last_o))
    else $error("stalled result changed");
  a_nf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> last_o && step_x_o == 3'd0 && step_y_o == 3'd0)
    else $error("bad not-found item");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_q)
    else $error("result without item");

endmodule

bind grid_astar_path_finder gap_checker u_gap_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .found_o, .step_x_o, .step_y_o, .last_o);

// ----- sim/grid_astar_path_finder_tb.sv -----
// ----------------------------------------------------------------------------
// grid_astar_path_finder_tb: self-checking bench for the grid A* path finder
// Drives map writes and path searches, predicts each path with an in-bench
// A* search and compares every result item in order, across idle and stall phases.
// ----------------------------------------------------------------------------
module grid_astar_path_finder_tb;
  import gap_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Side = 8;
  localparam int Cells = Side * Side;
  localparam int StallLimit = 20000;

  typedef struct packed {
    logic       found;
    logic [2:0] step_x;
    logic [2:0] step_y;
    logic       last;
  } step_t;

  class path_board;
    logic        wall[Cells];
    step_t       pending_steps[$];
    int          errors;

    function new();
      foreach (wall[i]) wall[i] = 1'b0;
      errors = 0;
    endfunction

    function void add_step(step_t st);
      pending_steps.insert(pending_steps.size(), st);
    endfunction

    function int dist_est(int x, int y, int gx, int gy);
      int dx, dy;
      int d2;
      dx = (x > gx) ? x - gx : gx - x;
      dy = (y > gy) ? y - gy : gy - y;
      d2 = dx * dx + dy * dy;
      case (d2)
        0: return 0;      1: return 1000;   2: return 1414;   4: return 2000;
        5: return 2236;   8: return 2828;   9: return 3000;   10: return 3162;
        13: return 3606;  16: return 4000;  17: return 4123;  18: return 4243;
        20: return 4472;  25: return 5000;  26: return 5099;  29: return 5385;
        32: return 5657;  34: return 5831;  36: return 6000;  37: return 6083;
        40: return 6325;  41: return 6403;  45: return 6708;  49: return 7000;
        50: return 7071;  52: return 7211;  53: return 7280;  58: return 7616;
        61: return 7810;  64: return 8000;  65: return 8062;  72: return 8485;
        74: return 8602;  85: return 9220;  98: return 9899;
        default: return 0;
      endcase
    endfunction

    function void note_item(logic kind, logic [2:0] sx, logic [2:0] sy, logic blk,
                            logic [2:0] gx, logic [2:0] gy);
      int          g_cost[Cells];
      int          from[Cells];
      logic        open[Cells];
      int          chain[$];
      int          s, g, cur, cx, cy, nx, ny, nb, at;
      int          f, best_f, tent;
      int          ddx[8] = '{0, 1, 1, 1, 0, -1, -1, -1};
      int          ddy[8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
      if (kind == KindWrite) begin
        wall[sy * Side + sx] = blk;
        return;
      end
      s = sy * Side + sx;
      g = gy * Side + gx;
      if (s == g) begin
        add_step('{1'b1, sx, sy, 1'b1});
        return;
      end
      foreach (g_cost[i]) begin
        g_cost[i] = Unreached;
        open[i] = 1'b0;
        from[i] = 0;
      end
      g_cost[s] = 0;
      open[s] = 1'b1;
      forever begin
        cur = -1;
        best_f = 0;
        for (int i = 0; i < Cells; i++) begin
          if (!open[i]) continue;
          f = g_cost[i] + dist_est(i % Side, i / Side, gx, gy);
          if (cur < 0 || f < best_f) begin
            cur = i;
            best_f = f;
          end
        end
        if (cur < 0) break;
        open[cur] = 1'b0;
        if (cur == g) break;
        cx = cur % Side;
        cy = cur / Side;
        for (int d = 0; d < 8; d++) begin
          nx = cx + ddx[d];
          ny = cy + ddy[d];
          if (nx < 0 || nx >= Side || ny < 0 || ny >= Side) continue;
          nb = ny * Side + nx;
          if (wall[nb]) continue;
          tent = g_cost[cur] + ((d % 2) ? CostDiag : CostStraight);
          if (tent < Unreached && tent < g_cost[nb]) begin
            g_cost[nb] = tent;
            from[nb] = cur;
            open[nb] = 1'b1;
          end
        end
      end
      if (g_cost[g] >= Unreached) begin
        add_step('{1'b0, 3'd0, 3'd0, 1'b1});
        return;
      end
      at = g;
      while (at != s) begin
        if (chain.size() >= 63) begin
          add_step('{1'b0, 3'd0, 3'd0, 1'b1});
          return;
        end
        chain.push_front(at);
        at = from[at];
      end
      chain.push_front(s);
      foreach (chain[k])
        add_step('{1'b1, 3'(chain[k] % Side), 3'(chain[k] / Side),
                   k == chain.size() - 1});
    endfunction

    function void check_step(step_t got);
      step_t want;
      if (pending_steps.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected step %p", got);
        return;
      end
      want = pending_steps.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("step mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       kind_i = 1'b0;
  logic [2:0] cell_x_i = '0;
  logic [2:0] cell_y_i = '0;
  logic       blocked_i = 1'b0;
  logic [2:0] goal_x_i = '0;
  logic [2:0] goal_y_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       found_o;
  logic [2:0] step_x_o;
  logic [2:0] step_y_o;
  logic       last_o;

  path_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  grid_astar_path_finder uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .cell_x_i, .cell_y_i,
    .blocked_i, .goal_x_i, .goal_y_i, .out_valid_o, .out_stall_i, .found_o,
    .step_x_o, .step_y_o, .last_o
  );

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) board.check_step({found_o, step_x_o, step_y_o, last_o});
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin
    if (quiet_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_item(logic kind, logic [2:0] sx, logic [2:0] sy, logic blk,
                           logic [2:0] gx, logic [2:0] gy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    kind_i <= kind;
    cell_x_i <= sx;
    cell_y_i <= sy;
    blocked_i <= blk;
    goal_x_i <= gx;
    goal_y_i <= gy;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(kind, sx, sy, blk, gx, gy);
    @(negedge clk_i);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45)
      send_item(KindWrite, 3'($urandom), 3'($urandom), ($urandom_range(99) < 30),
                3'($urandom), 3'($urandom));
    else if (pick < 50)
      send_item(KindWrite, 3'($urandom), 3'($urandom), 1'b0, 3'($urandom), 3'($urandom));
    else
      send_item(KindFind, 3'($urandom), 3'($urandom), 1'($urandom), 3'($urandom),
                3'($urandom));
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // corners, adjacent and diagonal steps on an open map
    send_item(KindFind, 0, 0, 1, 7, 7);
    send_item(KindFind, 7, 7, 0, 0, 0);
    send_item(KindFind, 7, 0, 0, 0, 7);
    send_item(KindFind, 3, 3, 0, 3, 3);
    send_item(KindFind, 2, 2, 0, 3, 3);
    send_item(KindFind, 2, 2, 0, 2, 3);
    // wall across column 4 with a gap at the bottom
    for (int y = 0; y < 7; y++) send_item(KindWrite, 4, y, 1, 7, 7);
    send_item(KindFind, 0, 3, 0, 7, 3);
    // blocked goal, blocked start, start equal to blocked goal
    send_item(KindFind, 0, 0, 0, 4, 2);
    send_item(KindFind, 4, 2, 0, 6, 2);
    send_item(KindFind, 4, 2, 0, 4, 2);
    // seal the gap: goal unreachable
    send_item(KindWrite, 4, 7, 1, 0, 0);
    send_item(KindFind, 0, 0, 0, 7, 7);
    for (int y = 0; y < 8; y++) send_item(KindWrite, 4, y, 0, 0, 0);
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 84 : 32) : 0;
      recv_stall_pct = (phase == 2) ? 84 : (phase == 3) ? 32 : 0;
      for (int n = 0; n < 28; n++) random_item();
    end
    in_valid_i <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (board.pending_steps.size() != 0) @(negedge clk_i);
    repeat (6000) @(negedge clk_i);
    if (board.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
